[rtl/trapezoid_motion_profile_defines.svh]
// Assertion macros shared by the RTL. Both expect clk and rst in scope.
`ifndef TRAPEZOID_MOTION_PROFILE_DEFINES_SVH
`define TRAPEZOID_MOTION_PROFILE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define TMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tmp_pkg.sv]
package tmp_pkg;

  // Field widths
  localparam int TIME_W    = 20;
  localparam int POS_W     = 32;
  localparam int SEG_W     = 3;
  localparam int RAMP_W    = 16;
  localparam int REG_IDX_W = 2;

  // Time format
  localparam int Q16_FRAC          = 16;
  localparam int TIME_FRAC_BITS_DEF = 16;
  localparam logic [Q16_FRAC:0]   Q16_ONE  = 17'h10000;
  localparam logic [RAMP_W-1:0]   Q16_HALF = 16'h8000;

  // Datapath widths
  localparam int DIST_W = POS_W + 1;   // end - start, exact
  localparam int MAG_W  = POS_W;       // |end - start| <= 2^32 - 1
  localparam int NUMR_W = 31;          // t^2 <= 2^30, 2t - A < 2^17
  localparam int DEN_W  = 32;          // 2A(1-A) <= 2^31
  localparam int PROD_W = MAG_W + NUMR_W;
  localparam int DIVD_W = 64;
  localparam int QUO_W  = 33;          // quotient <= 2^32
  localparam int SUM_W  = QUO_W + 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_START_POS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_END_POS       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_FRACTION = 2'd2;

  typedef enum logic [SEG_W-1:0] {
    SEG_BEFORE = 3'd0,
    SEG_ACCEL  = 3'd1,
    SEG_CRUISE = 3'd2,
    SEG_DECEL  = 3'd3,
    SEG_AFTER  = 3'd4
  } seg_t;

  // Per-word control that rides along the pipeline
  typedef struct packed {
    logic valid;
    seg_t seg;
    logic neg;
  } tag_t;

endpackage

[rtl/tmp_div.sv]
module tmp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  tmp_pkg::tag_t              in_tag,
  input  logic [tmp_pkg::DIVD_W-1:0] in_num,
  input  logic [tmp_pkg::DEN_W-1:0]  in_den,
  output tmp_pkg::tag_t              out_tag,
  output logic [tmp_pkg::QUO_W-1:0]  out_quo
);
  import tmp_pkg::*;

  // One quotient bit per stage, restoring long division
  tag_t              tag [QUO_W];
  logic [DEN_W-1:0]  rem [QUO_W];
  logic [DEN_W-1:0]  den [QUO_W];
  logic [QUO_W-1:0]  nlo [QUO_W];
  logic [QUO_W-1:0]  quo [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    tag_t             tag_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] nlo_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fit;

    if (k == 0) begin : g_first
      // top dividend bits already sit below the divisor
      assign tag_in = in_tag;
      assign rem_in = DEN_W'(in_num[DIVD_W-1:QUO_W]);
      assign den_in = in_den;
      assign nlo_in = in_num[QUO_W-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign tag_in = tag[k-1];
      assign rem_in = rem[k-1];
      assign den_in = den[k-1];
      assign nlo_in = nlo[k-1];
      assign quo_in = quo[k-1];
    end

    // bring down the next dividend bit and trial-subtract
    assign trial = {rem_in, nlo_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fit   = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[k] <= '0;
      end else begin
        tag[k] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      den[k] <= den_in;
      nlo[k] <= nlo_in << 1;
      quo[k] <= {quo_in[QUO_W-2:0], fit};
    end
  end

  assign out_tag = tag[QUO_W-1];
  assign out_quo = quo[QUO_W-1];

endmodule

[rtl/trapezoid_motion_profile.sv]
// Trapezoidal motion profile, position form. Each word on start/time_point (accepted when
// start is high and busy is low) is one normalised time sample; the block returns the position
// on a ramp-cruise-ramp move from start_pos to end_pos, saturated to signed Q16.16, plus the
// segment the sample falls in. A new word may be given every clock cycle while busy is low.
// Every result appears on position/segment with done high for exactly one cycle, in order;
// the receiver cannot hold results off and none is dropped. Results come from the exact
// rounded division, a 33-stage pipelined divider retiring one quotient bit per stage, behind
// four stages of decode and multiply. busy is high only during and just after reset.
// Registers are written through wr_en/wr_index/wr_data; the user must write them only while
// no result is outstanding, as the block does not enforce it. Unknown indexes are ignored.
`include "trapezoid_motion_profile_defines.svh"

module trapezoid_motion_profile #(
  parameter int TIME_FRAC_BITS = tmp_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [tmp_pkg::TIME_W-1:0] time_point,
  input  logic                              wr_en,
  input  logic [tmp_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [tmp_pkg::POS_W-1:0]         wr_data,
  output logic                              done,
  output logic signed [tmp_pkg::POS_W-1:0]  position,
  output logic [tmp_pkg::SEG_W-1:0]         segment
);
  import tmp_pkg::*;

  localparam int SH_L = (TIME_FRAC_BITS < Q16_FRAC) ? Q16_FRAC - TIME_FRAC_BITS : 0;
  localparam int SH_R = (TIME_FRAC_BITS > Q16_FRAC) ? TIME_FRAC_BITS - Q16_FRAC : 0;
  localparam int TW   = TIME_W + SH_L;
  localparam int LAT  = QUO_W + 5;

  // Configuration registers
  logic signed [POS_W-1:0] start_pos;
  logic signed [POS_W-1:0] end_pos;
  logic [RAMP_W-1:0]       ramp_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos     <= '0;
      end_pos       <= '0;
      ramp_fraction <= 16'h4000;
    end else if (wr_en) begin
      case (wr_index)
        REG_START_POS:     start_pos     <= wr_data;
        REG_END_POS:       end_pos       <= wr_data;
        REG_RAMP_FRACTION: ramp_fraction <= wr_data[RAMP_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1: time scaling and segment decode ----------------
  logic signed [TW-1:0] t_wide;
  logic signed [TW-1:0] t_q;
  logic signed [TW-1:0] a_s;
  logic signed [TW-1:0] uma_s;
  logic signed [TW-1:0] one_s;
  logic [RAMP_W-1:0]    a_c;
  logic [Q16_FRAC:0]    uma;
  logic [Q16_FRAC:0]    r_full;
  seg_t                 seg_d;

  assign t_wide = TW'(time_point);
  assign t_q    = (t_wide <<< SH_L) >>> SH_R;

  always_comb begin
    // zero ramp acts as the smallest ramp, above one half clips to one half
    if (ramp_fraction == '0) begin
      a_c = RAMP_W'(1);
    end else if (ramp_fraction > Q16_HALF) begin
      a_c = Q16_HALF;
    end else begin
      a_c = ramp_fraction;
    end
  end

  assign uma    = Q16_ONE - {1'b0, a_c};
  assign a_s    = TW'(a_c);
  assign uma_s  = TW'(uma);
  assign one_s  = TW'(Q16_ONE);
  assign r_full = Q16_ONE - t_q[Q16_FRAC:0];

  always_comb begin
    if (t_q[TW-1]) begin
      seg_d = SEG_BEFORE;
    end else if (t_q < a_s) begin
      seg_d = SEG_ACCEL;
    end else if (t_q < uma_s) begin
      seg_d = SEG_CRUISE;
    end else if (t_q <= one_s) begin
      seg_d = SEG_DECEL;
    end else begin
      seg_d = SEG_AFTER;
    end
  end

  logic                      s1_valid;
  seg_t                      s1_seg;
  logic [RAMP_W-1:0]         s1_ramp_var;
  logic [Q16_FRAC:0]         s1_lin;
  logic [RAMP_W-1:0]         s1_a;
  logic [Q16_FRAC:0]         s1_uma;
  logic signed [DIST_W-1:0]  s1_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_seg      <= seg_d;
    s1_ramp_var <= (seg_d == SEG_ACCEL) ? t_q[RAMP_W-1:0] : r_full[RAMP_W-1:0];
    s1_lin      <= {t_q[Q16_FRAC-1:0], 1'b0} - {1'b0, a_c};
    s1_a        <= a_c;
    s1_uma      <= uma;
    s1_dist     <= $signed({end_pos[POS_W-1], end_pos})
                 - $signed({start_pos[POS_W-1], start_pos});
  end

  // ---------------- stage 2: squares, denominators, magnitude ----------------
  logic [2*RAMP_W-1:0]    sq;
  logic [2*Q16_FRAC:0]    ramp_prod;
  logic [DIST_W-1:0]      dist_neg;

  assign sq        = s1_ramp_var * s1_ramp_var;
  assign ramp_prod = (2 * Q16_FRAC + 1)'(s1_a) * (2 * Q16_FRAC + 1)'(s1_uma);
  assign dist_neg  = -s1_dist;

  tag_t               s2_tag;
  logic [MAG_W-1:0]   s2_mag;
  logic [NUMR_W-1:0]  s2_num;
  logic [DEN_W-1:0]   s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
    end else begin
      s2_tag.valid <= s1_valid;
      s2_tag.seg   <= s1_seg;
      // deceleration is measured back from the end
      s2_tag.neg   <= s1_dist[DIST_W-1] ^ (s1_seg == SEG_DECEL);
    end
  end

  always_ff @(posedge clk) begin
    s2_mag <= s1_dist[DIST_W-1] ? dist_neg[MAG_W-1:0] : s1_dist[MAG_W-1:0];
    if (s1_seg == SEG_CRUISE) begin
      s2_num <= NUMR_W'(s1_lin);
      s2_den <= DEN_W'({s1_uma, 1'b0});
    end else begin
      s2_num <= sq[NUMR_W-1:0];
      s2_den <= {ramp_prod[DEN_W-2:0], 1'b0};
    end
  end

  // ---------------- stage 3: distance times numerator ----------------
  tag_t               s3_tag;
  logic [PROD_W-1:0]  s3_prod;
  logic [DEN_W-1:0]   s3_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag <= '0;
    end else begin
      s3_tag <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    s3_prod <= PROD_W'(s2_mag) * PROD_W'(s2_num);
    s3_den  <= s2_den;
  end

  // ---------------- stage 4: add half divisor for round-to-nearest ----------------
  tag_t               s4_tag;
  logic [DIVD_W-1:0]  s4_num;
  logic [DEN_W-1:0]   s4_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag <= '0;
    end else begin
      s4_tag <= s3_tag;
    end
  end

  always_ff @(posedge clk) begin
    s4_num <= DIVD_W'(s3_prod) + DIVD_W'(s3_den >> 1);
    s4_den <= s3_den;
  end

  // ---------------- pipelined divider ----------------
  tag_t              div_tag;
  logic [QUO_W-1:0]  div_quo;

  tmp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (s4_tag),
    .in_num  (s4_num),
    .in_den  (s4_den),
    .out_tag (div_tag),
    .out_quo (div_quo)
  );

  // ---------------- output stage: offset from base, saturate ----------------
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] quo_s;
  logic signed [SUM_W-1:0] sum;
  logic                    fits;
  logic signed [POS_W-1:0] pos_d;

  always_comb begin
    if (div_tag.seg inside {SEG_DECEL, SEG_AFTER}) begin
      base = SUM_W'(end_pos);
    end else begin
      base = SUM_W'(start_pos);
    end
    quo_s = $signed(SUM_W'(div_quo));
    if (div_tag.seg inside {SEG_ACCEL, SEG_CRUISE, SEG_DECEL}) begin
      sum = div_tag.neg ? base - quo_s : base + quo_s;
    end else begin
      sum = base;
    end
    fits = (&sum[SUM_W-1:POS_W-1]) | ~(|sum[SUM_W-1:POS_W-1]);
    if (fits) begin
      pos_d = sum[POS_W-1:0];
    end else if (sum[SUM_W-1]) begin
      pos_d = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_d = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    position <= pos_d;
    segment  <= div_tag.seg;
  end

  // ---------------- checks ----------------
  `TMP_ASSERT_NOW(a_done_latency, done, $past(accept, LAT), "result without a word accepted")
  `TMP_ASSERT_NOW(a_div_latency, div_tag.valid, $past(s4_tag.valid, QUO_W), "divider slip")
  `TMP_ASSERT_NEXT(a_never_busy, !busy, !busy, "busy raised outside reset")

endmodule
